### rtl/mrf_pkg.sv
// Shared types and constants for the Modbus RTU request framer.
package mrf_pkg;

  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned LEN_W       = 9;
  localparam int unsigned STATUS_W    = 2;
  localparam int unsigned PAYLOAD_W   = 32;
  localparam int unsigned CRC_W       = 16;
  localparam int unsigned DISCARD_W   = 32;
  localparam int unsigned PAYLOAD_NBYTES = 4;
  localparam int unsigned DCNT_W      = 3;
  localparam int unsigned IN_TDATA_W  = 8;
  localparam int unsigned OUT_FIELDS_W = STATUS_W + 2 * BYTE_W + PAYLOAD_W + CRC_W + DISCARD_W;
  localparam int unsigned OUT_TDATA_W = ((OUT_FIELDS_W + 7) / 8) * 8;

  localparam logic [BYTE_W-1:0] SLAVE_ADDRESS_RST = 8'h01;
  localparam logic [LEN_W-1:0]  MAX_FRAME_LEN_RST = 9'd256;

  typedef enum logic [0:0] {
    REG_SLAVE_ADDRESS = 1'b0,
    REG_MAX_FRAME_LEN = 1'b1
  } cfg_reg_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_NONE    = 2'd0,
    STATUS_FRAME   = 2'd1,
    STATUS_DISCARD = 2'd2
  } status_t;

  typedef struct packed {
    logic [BYTE_W-1:0] slave_address;
    logic [LEN_W-1:0]  max_frame_len;
  } cfg_t;

  typedef struct packed {
    logic [DISCARD_W-1:0] discard_total;
    logic [CRC_W-1:0]     crc_received;
    logic [PAYLOAD_W-1:0] payload;
    logic [BYTE_W-1:0]    function_code;
    logic [BYTE_W-1:0]    frame_address;
    status_t              status;
  } result_t;

endpackage

### rtl/modbus_rtu_request_framer_top.sv
// Top level of the Modbus RTU request framer.
//
// Input stream s_*: one received byte per request in s_tdata[7:0].
// Output stream m_*: one result per accepted byte, holding status
// (none / frame complete / overlength discard), frame fields and the
// running discard total. Frame fields read zero unless status is frame.
// Config port: cfg_wr_en with cfg_index 0 = slave address, 1 = max frame
// length, written by the user only while the framer is idle; the block
// does not enforce this. Bytes pass the input then the output register.
// Throughput: one byte per cycle while m_tready lets the output drain,
// set by the state update between the input and output registers.
// Reset: state, counters and registers return to defaults (address 1,
// max length 256); both stream stages come up empty.
// Stall: when m_tready is low the result holds, the input register
// keeps one more byte, then s_tready drops until the result is taken.
module modbus_rtu_request_framer_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [mrf_pkg::IN_TDATA_W-1:0]    s_tdata,   // [7:0] rx_byte
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // [1:0] status, [9:2] frame_address, [17:10] function_code,
  // [49:18] payload, [65:50] crc_received, [97:66] discard_total, rest zero
  output logic [mrf_pkg::OUT_TDATA_W-1:0]   m_tdata,
  input  logic                              cfg_wr_en,
  input  logic [0:0]                        cfg_index,
  input  logic [mrf_pkg::LEN_W-1:0]         cfg_data
);

  mrf_pkg::cfg_t                 cfg;
  mrf_pkg::result_t              result;
  logic                          in_valid;
  logic [mrf_pkg::BYTE_W-1:0]    in_byte;
  logic                          can_load;
  logic                          advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.slave_address <= mrf_pkg::SLAVE_ADDRESS_RST;
      cfg.max_frame_len <= mrf_pkg::MAX_FRAME_LEN_RST;
    end else if (cfg_wr_en) begin
      case (mrf_pkg::cfg_reg_t'(cfg_index))
        mrf_pkg::REG_SLAVE_ADDRESS: cfg.slave_address <= cfg_data[mrf_pkg::BYTE_W-1:0];
        mrf_pkg::REG_MAX_FRAME_LEN: cfg.max_frame_len <= cfg_data;
        default: ;
      endcase
    end
  end

  assign advance = in_valid && can_load;

  mrf_in_stage u_in (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_byte   (s_tdata[mrf_pkg::BYTE_W-1:0]),
    .advance  (advance),
    .in_valid (in_valid),
    .in_byte  (in_byte)
  );

  mrf_core u_core (
    .clk     (clk),
    .rst     (rst),
    .fire    (advance),
    .rx_byte (in_byte),
    .cfg     (cfg),
    .result  (result)
  );

  mrf_out_stage u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (advance),
    .result   (result),
    .can_load (can_load),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid right after reset");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled while output stage is empty");

  a_fields_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tdata[1:0] != mrf_pkg::STATUS_FRAME)) |-> (m_tdata[65:2] == '0))
    else $error("frame fields nonzero without a complete frame");

  a_status_legal: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ((m_tdata[1:0] == mrf_pkg::STATUS_NONE) ||
                  (m_tdata[1:0] == mrf_pkg::STATUS_FRAME) ||
                  (m_tdata[1:0] == mrf_pkg::STATUS_DISCARD)))
    else $error("illegal status code");

endmodule

### rtl/mrf_in_stage.sv
// Input register stage: captures one received byte per request.
module mrf_in_stage (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [mrf_pkg::BYTE_W-1:0]    s_byte,
  input  logic                          advance,
  output logic                          in_valid,
  output logic [mrf_pkg::BYTE_W-1:0]    in_byte
);

  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
    if (s_tready && s_tvalid) begin
      in_byte <= s_byte;
    end
  end

endmodule

### rtl/mrf_core.sv
// Framing state machine: byte count, field capture and overlength discard.
module mrf_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          fire,
  input  logic [mrf_pkg::BYTE_W-1:0]    rx_byte,
  input  mrf_pkg::cfg_t                 cfg,
  output mrf_pkg::result_t              result
);

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_ADDR = 2'd1,
    PH_DATA = 2'd2,
    PH_CRC  = 2'd3
  } phase_t;

  phase_t                            phase, phase_next;
  logic [mrf_pkg::LEN_W-1:0]         byte_count, byte_count_next;
  logic [mrf_pkg::LEN_W:0]           count_inc;
  logic [mrf_pkg::DCNT_W-1:0]        payload_count, payload_count_next;
  logic [mrf_pkg::BYTE_W-1:0]        payload_bytes [mrf_pkg::PAYLOAD_NBYTES];
  logic [mrf_pkg::BYTE_W-1:0]        held_address, held_address_next;
  logic [mrf_pkg::BYTE_W-1:0]        held_function, held_function_next;
  logic [mrf_pkg::BYTE_W-1:0]        crc_low_byte, crc_low_byte_next;
  logic                              crc_low_seen, crc_low_seen_next;
  logic [mrf_pkg::DISCARD_W-1:0]     discard_counter, discard_counter_next;
  logic                              overlength;
  logic                              data_wr;

  assign count_inc  = {1'b0, byte_count} + {{mrf_pkg::LEN_W{1'b0}}, 1'b1};
  assign overlength = count_inc > {1'b0, cfg.max_frame_len};
  assign data_wr    = !overlength && (phase == PH_DATA);

  always_comb begin
    phase_next           = phase;
    byte_count_next      = count_inc[mrf_pkg::LEN_W-1:0];
    payload_count_next   = payload_count;
    held_address_next    = held_address;
    held_function_next   = held_function;
    crc_low_byte_next    = crc_low_byte;
    crc_low_seen_next    = crc_low_seen;
    discard_counter_next = discard_counter;
    result               = '0;
    result.status        = mrf_pkg::STATUS_NONE;
    if (overlength) begin
      phase_next           = PH_IDLE;
      byte_count_next      = '0;
      payload_count_next   = '0;
      held_address_next    = '0;
      held_function_next   = '0;
      crc_low_byte_next    = '0;
      crc_low_seen_next    = 1'b0;
      discard_counter_next = discard_counter + 32'd1;
      result.status        = mrf_pkg::STATUS_DISCARD;
    end else begin
      case (phase)
        PH_IDLE: begin
          if (rx_byte == cfg.slave_address) begin
            held_address_next = rx_byte;
            byte_count_next   = 9'd1;
            phase_next        = PH_ADDR;
          end
        end
        PH_ADDR: begin
          held_function_next = rx_byte;
          payload_count_next = '0;
          phase_next         = PH_DATA;
        end
        PH_DATA: begin
          payload_count_next = payload_count + 3'd1;
          if (payload_count_next >= mrf_pkg::DCNT_W'(mrf_pkg::PAYLOAD_NBYTES)) begin
            phase_next        = PH_CRC;
            crc_low_seen_next = 1'b0;
          end
        end
        PH_CRC: begin
          if (!crc_low_seen) begin
            crc_low_byte_next = rx_byte;
            crc_low_seen_next = 1'b1;
          end else begin
            phase_next           = PH_IDLE;
            result.status        = mrf_pkg::STATUS_FRAME;
            result.frame_address = held_address;
            result.function_code = held_function;
            result.payload       = {payload_bytes[0], payload_bytes[1],
                                    payload_bytes[2], payload_bytes[3]};
            result.crc_received  = {rx_byte, crc_low_byte};
          end
        end
        default: phase_next = PH_IDLE;
      endcase
    end
    result.discard_total = discard_counter_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_IDLE;
      byte_count      <= '0;
      payload_count   <= '0;
      held_address    <= '0;
      held_function   <= '0;
      crc_low_byte    <= '0;
      crc_low_seen    <= 1'b0;
      discard_counter <= '0;
      for (int i = 0; i < mrf_pkg::PAYLOAD_NBYTES; i++) begin
        payload_bytes[i] <= '0;
      end
    end else if (fire) begin
      phase           <= phase_next;
      byte_count      <= byte_count_next;
      payload_count   <= payload_count_next;
      held_address    <= held_address_next;
      held_function   <= held_function_next;
      crc_low_byte    <= crc_low_byte_next;
      crc_low_seen    <= crc_low_seen_next;
      discard_counter <= discard_counter_next;
      if (overlength) begin
        for (int i = 0; i < mrf_pkg::PAYLOAD_NBYTES; i++) begin
          payload_bytes[i] <= '0;
        end
      end else if (data_wr) begin
        payload_bytes[payload_count[1:0]] <= rx_byte;
      end
    end
  end

endmodule

### rtl/mrf_out_stage.sv
// Output register stage: holds one result until the receiver takes it.
module mrf_out_stage (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              load,
  input  mrf_pkg::result_t                  result,
  output logic                              can_load,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [mrf_pkg::OUT_TDATA_W-1:0]   m_tdata
);

  assign can_load = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (can_load) begin
      m_tvalid <= load;
    end
    if (can_load && load) begin
      m_tdata <= {{(mrf_pkg::OUT_TDATA_W - mrf_pkg::OUT_FIELDS_W){1'b0}}, result};
    end
  end

endmodule

### bench/tb.sv
// Self-checking bench for the Modbus RTU request framer: directed table, then random phases.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NROWS          = 33;
  localparam int NPHASE         = 10;
  localparam int PHASE_ITEMS    = 80;
  localparam int LONG_HOLD      = 50;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int RAND_LEN       = 1000;  // len_plan entry meaning "pick a random limit"

  typedef enum logic [1:0] {FR_IDLE, FR_ADDR, FR_DATA, FR_CRC} framer_phase_t;
  typedef enum logic [1:0] {ROW_RX, ROW_SET_ADDR, ROW_SET_LEN} row_kind_t;

  typedef struct packed {
    row_kind_t        kind;
    logic [8:0]       val;
    logic             typed;
    mrf_pkg::status_t st;
    logic [7:0]       fa;
    logic [7:0]       fc;
    logic [31:0]      pl;
    logic [15:0]      crc;
    logic [31:0]      tot;
  } stim_row_t;

  logic                            clk       = 1'b0;
  logic                            rst       = 1'b1;
  logic                            s_tvalid  = 1'b0;
  logic                            s_tready;
  logic [mrf_pkg::IN_TDATA_W-1:0]  s_tdata   = '0;
  logic                            m_tvalid;
  logic                            m_tready  = 1'b0;
  logic [mrf_pkg::OUT_TDATA_W-1:0] m_tdata;
  logic                            cfg_wr_en = 1'b0;
  logic [0:0]                      cfg_index = '0;
  logic [mrf_pkg::LEN_W-1:0]       cfg_data  = '0;

  // predictor state
  framer_phase_t fr_phase    = FR_IDLE;
  logic [8:0]    fr_count    = '0;
  int            pay_idx     = 0;
  logic [7:0]    pay_bytes [4] = '{default: 8'h00};
  logic [7:0]    held_addr   = '0;
  logic [7:0]    held_func   = '0;
  logic [7:0]    crc_lo      = '0;
  logic          crc_lo_seen = 1'b0;
  logic [31:0]   drops       = '0;
  logic [7:0]    slave_q     = mrf_pkg::SLAVE_ADDRESS_RST;
  logic [8:0]    max_len_q   = mrf_pkg::MAX_FRAME_LEN_RST;

  mrf_pkg::result_t expected_q [$];
  int unsigned mismatches    = 0;
  int unsigned idle_cycles   = 0;
  int unsigned phase_items   = 0;
  int unsigned sink_hold     = 0;
  logic        quiet         = 1'b0;
  logic        long_hold_req = 1'b0;

  int unsigned len_plan [NPHASE] = '{8, 0, 256, 20, 7, RAND_LEN, 511, 9, RAND_LEN, 256};

  stim_row_t plan [NROWS] = '{
    '{ROW_RX, 9'h000, 1'b1, mrf_pkg::STATUS_NONE, 8'h00, 8'h00, 32'h0, 16'h0000, 32'd0},
    '{ROW_RX, 9'h001, 1'b0, mrf_pkg::STATUS_NONE, 8'h00, 8'h00, 32'h0, 16'h0000, 32'd0},
    '{ROW_RX, 9'h003, 1'b0, mrf_pkg::STATUS_NONE, 8'h00, 8'h00, 32'h0, 16'h0000, 32'd0},
    '{ROW_RX, 9'h0FF, 1'b0, mrf_pkg::STATUS_NONE, 8'h00, 8'h00, 32'h0, 16'h0000, 32'd0},
    '{ROW_RX, 9'h000, 1'b0, mrf_pkg::STATUS_NONE, 8'h00, 8'h00, 32'h0, 16'h0000, 32'd0},
    '{ROW_RX, 9'h0FF, 1'b0, mrf_pkg::STATUS_NONE, 8'h00, 8'h00, 32'h0, 16'h0000, 32'd0},
    '{ROW_RX, 9'h000, 1'b0, mrf_pkg::STATUS_NONE, 8'h00, 8'h00, 32'h0, 16'h0000, 32'd0},
    '{ROW_RX, 9'h034, 1'b0, mrf_pkg::STATUS_NONE, 8'h00, 8'h00, 32'h0, 16'h0000, 32'd0},
    '{ROW_RX, 9'h012, 1'b1, mrf_pkg::STATUS_FRAME, 8'h01, 8'h03, 32'hFF00FF00, 16'h1234, 32'd0},
    '{ROW_RX, 9'h001, 1'b0, mrf_pkg::STATUS_NONE, 8'h00, 8'h00, 32'h0, 16'h0000, 32'd0},
    '{ROW_RX, 9'h006, 1'b0, mrf_pkg::STATUS_NONE, 8'h00, 8'h00, 32'h0, 16'h0000, 32'd0},
    '{ROW_RX, 9'h000, 1'b0, mrf_pkg::STATUS_NONE, 8'h00, 8'h00, 32'h0, 16'h0000, 32'd0},
    '{ROW_RX, 9'h0FF, 1'b0, mrf_pkg::STATUS_NONE, 8'h00, 8'h00, 32'h0, 16'h0000, 32'd0},
    '{ROW_RX, 9'h000, 1'b0, mrf_pkg::STATUS_NONE, 8'h00, 8'h00, 32'h0, 16'h0000, 32'd0},
    '{ROW_RX, 9'h0FF, 1'b0, mrf_pkg::STATUS_NONE, 8'h00, 8'h00, 32'h0, 16'h0000, 32'd0},
    '{ROW_RX, 9'h0FF, 1'b0, mrf_pkg::STATUS_NONE, 8'h00, 8'h00, 32'h0, 16'h0000, 32'd0},
    '{ROW_RX, 9'h0FF, 1'b1, mrf_pkg::STATUS_FRAME, 8'h01, 8'h06, 32'h00FF00FF, 16'hFFFF, 32'd0},
    // count sits at 8 after the frame; next idle byte goes over
    '{ROW_SET_LEN, 9'd8, 1'b0, mrf_pkg::STATUS_NONE, 8'h00, 8'h00, 32'h0, 16'h0000, 32'd0},
    '{ROW_RX, 9'h055, 1'b1, mrf_pkg::STATUS_DISCARD, 8'h00, 8'h00, 32'h0, 16'h0000, 32'd1},
    // zero limit: even the address byte is dropped
    '{ROW_SET_LEN, 9'd0, 1'b0, mrf_pkg::STATUS_NONE, 8'h00, 8'h00, 32'h0, 16'h0000, 32'd0},
    '{ROW_RX, 9'h001, 1'b1, mrf_pkg::STATUS_DISCARD, 8'h00, 8'h00, 32'h0, 16'h0000, 32'd2},
    '{ROW_SET_ADDR, 9'h0FF, 1'b0, mrf_pkg::STATUS_NONE, 8'h00, 8'h00, 32'h0, 16'h0000, 32'd0},
    // limit 7: frame cannot finish, address value reused as function code
    '{ROW_SET_LEN, 9'd7, 1'b0, mrf_pkg::STATUS_NONE, 8'h00, 8'h00, 32'h0, 16'h0000, 32'd0},
    '{ROW_RX, 9'h0FF, 1'b0, mrf_pkg::STATUS_NONE, 8'h00, 8'h00, 32'h0, 16'h0000, 32'd0},
    '{ROW_RX, 9'h0FF, 1'b0, mrf_pkg::STATUS_NONE, 8'h00, 8'h00, 32'h0, 16'h0000, 32'd0},
    '{ROW_RX, 9'h080, 1'b0, mrf_pkg::STATUS_NONE, 8'h00, 8'h00, 32'h0, 16'h0000, 32'd0},
    '{ROW_RX, 9'h07F, 1'b0, mrf_pkg::STATUS_NONE, 8'h00, 8'h00, 32'h0, 16'h0000, 32'd0},
    '{ROW_RX, 9'h001, 1'b0, mrf_pkg::STATUS_NONE, 8'h00, 8'h00, 32'h0, 16'h0000, 32'd0},
    '{ROW_RX, 9'h0FE, 1'b0, mrf_pkg::STATUS_NONE, 8'h00, 8'h00, 32'h0, 16'h0000, 32'd0},
    '{ROW_RX, 9'h0AA, 1'b0, mrf_pkg::STATUS_NONE, 8'h00, 8'h00, 32'h0, 16'h0000, 32'd0},
    '{ROW_RX, 9'h055, 1'b1, mrf_pkg::STATUS_DISCARD, 8'h00, 8'h00, 32'h0, 16'h0000, 32'd3},
    '{ROW_SET_LEN, 9'd256, 1'b0, mrf_pkg::STATUS_NONE, 8'h00, 8'h00, 32'h0, 16'h0000, 32'd0},
    '{ROW_SET_ADDR, 9'h001, 1'b0, mrf_pkg::STATUS_NONE, 8'h00, 8'h00, 32'h0, 16'h0000, 32'd0}
  };

  modbus_rtu_request_framer_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #6 clk = ~clk;

  function automatic mrf_pkg::result_t frame_byte(input logic [7:0] b);
    mrf_pkg::result_t r;
    logic [9:0]       next_cnt;
    r = '0;
    next_cnt = {1'b0, fr_count} + 10'd1;
    if (next_cnt > {1'b0, max_len_q}) begin
      fr_phase    = FR_IDLE;
      fr_count    = '0;
      pay_idx     = 0;
      pay_bytes   = '{default: 8'h00};
      held_addr   = '0;
      held_func   = '0;
      crc_lo      = '0;
      crc_lo_seen = 1'b0;
      drops       = drops + 32'd1;
      r.status    = mrf_pkg::STATUS_DISCARD;
    end else begin
      fr_count = next_cnt[8:0];
      case (fr_phase)
        FR_IDLE: begin
          if (b == slave_q) begin
            held_addr = b;
            fr_count  = 9'd1;
            fr_phase  = FR_ADDR;
          end
        end
        FR_ADDR: begin
          held_func = b;
          pay_idx   = 0;
          fr_phase  = FR_DATA;
        end
        FR_DATA: begin
          pay_bytes[pay_idx] = b;
          pay_idx++;
          if (pay_idx >= mrf_pkg::PAYLOAD_NBYTES) begin
            fr_phase    = FR_CRC;
            crc_lo_seen = 1'b0;
          end
        end
        default: begin
          if (!crc_lo_seen) begin
            crc_lo      = b;
            crc_lo_seen = 1'b1;
          end else begin
            fr_phase        = FR_IDLE;
            r.status        = mrf_pkg::STATUS_FRAME;
            r.frame_address = held_addr;
            r.function_code = held_func;
            r.payload       = {pay_bytes[0], pay_bytes[1], pay_bytes[2], pay_bytes[3]};
            r.crc_received  = {b, crc_lo};
          end
        end
      endcase
    end
    r.discard_total = drops;
    return r;
  endfunction

  // one request on the input stream, plus an optional idle burst after it
  task automatic send_rx(input logic [7:0] b, input logic typed,
                         input mrf_pkg::result_t typed_res);
    mrf_pkg::result_t r;
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    do @(posedge clk); while (!s_tready);
    r = frame_byte(b);
    expected_q.push_back(typed ? typed_res : r);
    phase_items++;
    if (!quiet && $urandom_range(0, 7) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  // register write once the framer has drained
  task automatic write_reg(input mrf_pkg::cfg_reg_t idx, input logic [8:0] val);
    s_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == mrf_pkg::REG_SLAVE_ADDRESS) slave_q = val[7:0];
    else max_len_q = val;
  endtask

  // result side ready, with random and long stalls
  initial begin
    forever begin
      @(posedge clk);
      if (sink_hold != 0) begin
        sink_hold--;
        m_tready <= 1'b0;
      end else if (long_hold_req) begin
        long_hold_req = 1'b0;
        sink_hold     = LONG_HOLD - 1;
        m_tready     <= 1'b0;
      end else if (!quiet && $urandom_range(0, 11) == 0) begin
        sink_hold = $urandom_range(0, 7);
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    mrf_pkg::result_t got;
    mrf_pkg::result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = mrf_pkg::result_t'(m_tdata[mrf_pkg::OUT_FIELDS_W-1:0]);
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: %h", m_tdata);
      end else begin
        want = expected_q.pop_front();
        if (got.status !== want.status || got.frame_address !== want.frame_address ||
            got.function_code !== want.function_code || got.payload !== want.payload ||
            got.crc_received !== want.crc_received ||
            got.discard_total !== want.discard_total) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: exp st=%0d fa=%h fc=%h pl=%h crc=%h tot=%h",
                     want.status, want.frame_address, want.function_code, want.payload,
                     want.crc_received, want.discard_total);
            $display("          got st=%0d fa=%h fc=%h pl=%h crc=%h tot=%h",
                     got.status, got.frame_address, got.function_code, got.payload,
                     got.crc_received, got.discard_total);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    mrf_pkg::result_t want;
    int unsigned      kind_sel;
    int unsigned      nbytes;
    logic [8:0]       len_val;
    logic [8:0]       addr_val;
    logic             paused;
    paused = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < NROWS; i++) begin
      case (plan[i].kind)
        ROW_SET_ADDR: write_reg(mrf_pkg::REG_SLAVE_ADDRESS, plan[i].val);
        ROW_SET_LEN:  write_reg(mrf_pkg::REG_MAX_FRAME_LEN, plan[i].val);
        default: begin
          want               = '0;
          want.status        = plan[i].st;
          want.frame_address = plan[i].fa;
          want.function_code = plan[i].fc;
          want.payload       = plan[i].pl;
          want.crc_received  = plan[i].crc;
          want.discard_total = plan[i].tot;
          send_rx(plan[i].val[7:0], plan[i].typed, want);
        end
      endcase
    end

    for (int p = 0; p < NPHASE; p++) begin
      len_val  = (len_plan[p] == RAND_LEN) ? 9'($urandom_range(8, 256)) : 9'(len_plan[p]);
      addr_val = (p == 0) ? 9'h000 : (p == 6) ? 9'h1FF : 9'($urandom_range(0, 511));
      write_reg(mrf_pkg::REG_MAX_FRAME_LEN, len_val);
      write_reg(mrf_pkg::REG_SLAVE_ADDRESS, addr_val);
      quiet = (p >= NPHASE - 2);
      if (p == 3) long_hold_req = 1'b1;
      phase_items = 0;
      while (phase_items < PHASE_ITEMS) begin
        if (p == 5 && phase_items >= 40 && !paused) begin
          paused = 1'b1;
          s_tvalid <= 1'b0;
          while (expected_q.size() != 0) @(posedge clk);
        end
        kind_sel = $urandom_range(0, 9);
        if (kind_sel <= 7) begin
          // address then a whole frame, or a truncated one
          send_rx(slave_q, 1'b0, '0);
          nbytes = (kind_sel == 7) ? $urandom_range(0, 6) : 7;
          repeat (nbytes)
            send_rx(($urandom_range(0, 5) == 0) ? {8{1'($urandom_range(0, 1))}}
                                                : 8'($urandom_range(0, 255)), 1'b0, '0);
        end else begin
          repeat ($urandom_range(1, 12)) send_rx(8'($urandom_range(0, 255)), 1'b0, '0);
        end
      end
    end

    s_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
